[hw/rtl/ped_pkg.sv]
`default_nettype none

package ped_pkg;

	localparam int IW = 64;
	localparam int CAP_BITS = 7;
	localparam int ITER_BITS = 6;

	localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};

	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd32;
	localparam logic [CAP_BITS-1:0] CAP_LIMIT = 7'd64;
	localparam logic [ITER_BITS-1:0] FAIL_ITERS = 6'd63;

	localparam logic [1:0] REG_AXIS_A = 2'd0;
	localparam logic [1:0] REG_AXIS_B = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;
	localparam logic [1:0] REG_ITER_CAP = 2'd3;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_SQ,
		OP_SQADD,
		OP_DIV,
		OP_SQRTQ,
		OP_SQRTW
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
		logic signed [IW-1:0] a;
		logic signed [IW-1:0] b;
	} alu_cmd_t;

	function automatic logic signed [IW-1:0] sat_add(input logic signed [IW-1:0] x,
			input logic signed [IW-1:0] y);
		logic signed [IW:0] s;
		s = {x[IW-1], x} + {y[IW-1], y};
		if (s[IW] != s[IW-1]) begin
			return s[IW] ? INT_MIN : INT_MAX;
		end
		return s[IW-1:0];
	endfunction

	function automatic logic signed [IW-1:0] sat_sub(input logic signed [IW-1:0] x,
			input logic signed [IW-1:0] y);
		logic signed [IW:0] s;
		s = {x[IW-1], x} - {y[IW-1], y};
		if (s[IW] != s[IW-1]) begin
			return s[IW] ? INT_MIN : INT_MAX;
		end
		return s[IW-1:0];
	endfunction

	function automatic logic signed [IW-1:0] sat_neg(input logic signed [IW-1:0] x);
		return (x == INT_MIN) ? INT_MAX : -x;
	endfunction

	function automatic logic [IW-1:0] mag(input logic signed [IW-1:0] x);
		return x[IW-1] ? IW'(-x) : IW'(x);
	endfunction

	// clamp a wide magnitude to the signed range, then apply the sign
	function automatic logic signed [IW-1:0] sat_mag(input logic [2*IW-1:0] m,
			input logic neg);
		logic signed [IW-1:0] v;
		v = (m[2*IW-1:IW-1] != '0) ? INT_MAX : m[IW-1:0];
		return neg ? -v : v;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/ped_alu.sv]
`default_nettype none

module ped_alu
	import ped_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire alu_cmd_t cmd,
	output logic done,
	output logic signed [IW-1:0] result
);

	localparam int DIV_BITS = IW + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_BITS + 1);

	alu_op_t op_q;
	logic busy_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IW-1:0] mcand_q;
	logic [2*IW-1:0] prod_q;
	logic [2*IW-1:0] w_q;
	logic [IW-1:0] den_q;
	logic [IW-1:0] rem_q;
	logic [DIV_BITS-1:0] num_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [2*IW-1:0] rad_q;
	logic [IW+1:0] srem_q;
	logic [IW-1:0] root_q;

	logic [IW:0] mul_sum;
	logic [IW:0] div_r2;
	logic div_ge;
	logic [IW:0] div_diff;
	logic [IW+3:0] sq_r2;
	logic [IW+3:0] sq_trial;
	logic sq_ge;
	logic [IW+3:0] sq_diff;

	always_comb begin
		mul_sum = {1'b0, prod_q[2*IW-1:IW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
		div_r2 = {rem_q, num_q[DIV_BITS-1]};
		div_ge = div_r2 >= {1'b0, den_q};
		div_diff = div_r2 - {1'b0, den_q};
		sq_r2 = {srem_q, rad_q[2*IW-1:2*IW-2]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_ge = sq_r2 >= sq_trial;
		sq_diff = sq_r2 - sq_trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			op_q <= OP_NONE;
		end else begin
			done <= 1'b0;
			if (cmd.start) begin
				op_q <= cmd.op;
				neg_q <= cmd.a[IW-1] ^ cmd.b[IW-1];
				case (cmd.op)
					OP_ADD: begin
						result <= sat_add(cmd.a, cmd.b);
						done <= 1'b1;
					end
					OP_SUB: begin
						result <= sat_sub(cmd.a, cmd.b);
						done <= 1'b1;
					end
					OP_MUL: begin
						mcand_q <= mag(cmd.a);
						prod_q <= {{IW{1'b0}}, mag(cmd.b)};
						cnt_q <= CNT_W'(IW);
						busy_q <= 1'b1;
					end
					OP_SQ, OP_SQADD: begin
						mcand_q <= mag(cmd.a);
						prod_q <= {{IW{1'b0}}, mag(cmd.a)};
						cnt_q <= CNT_W'(IW);
						busy_q <= 1'b1;
					end
					OP_DIV: begin
						if (cmd.a == '0) begin
							result <= '0;
							done <= 1'b1;
						end else if (cmd.b == '0) begin
							result <= cmd.a[IW-1] ? -INT_MAX : INT_MAX;
							done <= 1'b1;
						end else begin
							den_q <= mag(cmd.b);
							rem_q <= '0;
							num_q <= {mag(cmd.a), {FRAC_BITS{1'b0}}};
							quo_q <= '0;
							cnt_q <= CNT_W'(DIV_BITS);
							busy_q <= 1'b1;
						end
					end
					OP_SQRTQ: begin
						rad_q <= {{IW{1'b0}}, mag(cmd.a)} << FRAC_BITS;
						srem_q <= '0;
						root_q <= '0;
						cnt_q <= CNT_W'(IW);
						busy_q <= 1'b1;
					end
					OP_SQRTW: begin
						rad_q <= w_q;
						srem_q <= '0;
						root_q <= '0;
						cnt_q <= CNT_W'(IW);
						busy_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
					case (op_q)
						OP_MUL, OP_SQ, OP_SQADD: begin
							prod_q <= {mul_sum, prod_q[IW-1:1]};
						end
						OP_DIV: begin
							rem_q <= div_ge ? div_diff[IW-1:0] : div_r2[IW-1:0];
							quo_q <= {quo_q[DIV_BITS-2:0], div_ge};
							num_q <= num_q << 1;
						end
						OP_SQRTQ, OP_SQRTW: begin
							srem_q <= sq_ge ? sq_diff[IW+1:0] : sq_r2[IW+1:0];
							root_q <= {root_q[IW-2:0], sq_ge};
							rad_q <= rad_q << 2;
						end
						default: begin
						end
					endcase
				end else begin
					busy_q <= 1'b0;
					done <= 1'b1;
					case (op_q)
						OP_MUL: result <= sat_mag(prod_q >> FRAC_BITS, neg_q);
						OP_SQ: w_q <= prod_q;
						OP_SQADD: w_q <= w_q + prod_q;
						OP_DIV: result <= sat_mag((2*IW)'(quo_q), neg_q);
						OP_SQRTQ, OP_SQRTW: result <= root_q;
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/point_ellipse_distance.sv]
`default_nettype none

// Unsigned distance from a point to the axis-aligned ellipse set by axis_a and axis_b, with
// a signed closest point on it, in fixed point (FRAC_BITS fraction bits). Pulse start while
// busy is low; busy stays high until the one-cycle done strobe, which is issued exactly once
// per item and cannot be held off, so capture the result ports in that cycle. They then hold
// until the next result. Every add, subtract, multiply, divide and square root runs on one
// shared arithmetic unit; a multiply or square root works one bit a cycle over a 64-bit word.
// A general point runs Newton steps, and one that does not converge stops at the iteration
// cap and reports failure. Configuration writes take effect at once and belong between items.
module point_ellipse_distance
	import ped_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	localparam int AW = WORD_BITS - 1,
	localparam int TW = FRAC_BITS + 1,
	localparam int CFG_BITS = (AW > TW) ? ((AW > CAP_BITS) ? AW : CAP_BITS)
		: ((TW > CAP_BITS) ? TW : CAP_BITS)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [WORD_BITS-1:0] point_u,
	input wire logic signed [WORD_BITS-1:0] point_v,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [CFG_BITS-1:0] cfg_data,
	output logic done,
	output logic [AW-1:0] distance,
	output logic signed [WORD_BITS-1:0] closest_x,
	output logic signed [WORD_BITS-1:0] closest_y,
	output logic [ITER_BITS-1:0] iterations_used,
	output logic failed
);

	localparam logic signed [IW-1:0] ONE = 64'sd1 <<< FRAC_BITS;

	typedef enum logic [5:0] {
		S_IDLE, S_FOLD, S_BRANCH,
		S_N_ASQ, S_N_BSQ, S_N_VB, S_N_T, S_N_AU, S_N_BV,
		S_L_CHK, S_L_TPA, S_L_TPB, S_L_XA, S_L_YB, S_L_XA2, S_L_YB2, S_L_FS, S_L_F,
		S_L_FCHK, S_L_DA, S_L_DB, S_L_DS, S_L_D2, S_L_R, S_L_RCHK, S_L_T,
		S_F_X, S_F_Y,
		S_H_DX, S_H_SQX, S_H_DY, S_H_SQY, S_H_RT,
		S_A_BSQ, S_A_Q, S_A_LIM, S_A_CHK, S_A_ASQ, S_A_NUM, S_A_DEN, S_A_X, S_A_XA,
		S_A_XA2, S_A_S, S_A_RT, S_A_Y, S_A_UA, S_E_MAG,
		S_V_VB, S_V_MAG,
		S_FAIL, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		D_NONE, D_TMP, D_ASQ, D_BSQ, D_T, D_AU, D_BV, D_TPA, D_TPB, D_XA, D_YB,
		D_XA2, D_YB2, D_F, D_DER, D_X, D_Y, D_DIST
	} dst_t;

	logic [AW-1:0] axis_a_q;
	logic [AW-1:0] axis_b_q;
	logic [TW-1:0] tol_q;
	logic [CAP_BITS-1:0] cap_q;

	state_t state_q;
	logic issued_q;
	logic rx_q, ry_q, sw_q, fail_q;
	logic [CAP_BITS-1:0] iter_q;
	logic signed [IW-1:0] u_q, v_q, a_q, b_q;
	logic signed [IW-1:0] asq_q, bsq_q, t_q, au_q, bv_q, tpa_q, tpb_q;
	logic signed [IW-1:0] xa_q, yb_q, xa2_q, yb2_q, f_q, der_q, tmp_q, x_q, y_q;
	logic [IW-1:0] dist_q;

	alu_op_t uop_op;
	logic signed [IW-1:0] uop_a, uop_b;
	dst_t uop_dst;
	state_t uop_nxt;

	alu_cmd_t alu_cmd;
	logic alu_done;
	logic signed [IW-1:0] alu_res;

	logic signed [IW-1:0] eps;
	logic signed [IW-1:0] a_ext, b_ext;
	logic signed [IW-1:0] fu, fv;
	logic fold_rx, fold_ry, fold_sw;
	logic [CAP_BITS-1:0] cap_eff;
	logic signed [IW-1:0] xo, yo, x_sh, y_sh;
	logic [WORD_BITS-1:0] x_pk, y_pk;
	logic [AW-1:0] dist_pk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_a_q <= AW'(2) << FRAC_BITS;
			axis_b_q <= AW'(1) << FRAC_BITS;
			tol_q <= TW'(1);
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS_A: axis_a_q <= cfg_data[AW-1:0];
				REG_AXIS_B: axis_b_q <= cfg_data[AW-1:0];
				REG_TOLERANCE: tol_q <= cfg_data[TW-1:0];
				REG_ITER_CAP: cap_q <= cfg_data[CAP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// fold into the first quadrant, long axis along x
	always_comb begin
		eps = IW'(tol_q);
		a_ext = IW'(axis_a_q);
		b_ext = IW'(axis_b_q);
		fold_rx = u_q < -eps;
		fold_ry = v_q < -eps;
		fu = fold_rx ? sat_neg(u_q) : ((u_q <= eps) ? '0 : u_q);
		fv = fold_ry ? sat_neg(v_q) : ((v_q <= eps) ? '0 : v_q);
		fold_sw = a_ext < b_ext;
		cap_eff = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;
	end

	always_comb begin
		uop_op = OP_NONE;
		uop_a = '0;
		uop_b = '0;
		uop_dst = D_NONE;
		uop_nxt = state_q;
		case (state_q)
			S_N_ASQ: begin uop_op = OP_MUL; uop_a = a_q; uop_b = a_q; uop_dst = D_ASQ;
				uop_nxt = S_N_BSQ; end
			S_N_BSQ: begin uop_op = OP_MUL; uop_a = b_q; uop_b = b_q; uop_dst = D_BSQ;
				uop_nxt = S_N_VB; end
			S_N_VB: begin uop_op = OP_SUB; uop_a = v_q; uop_b = b_q; uop_dst = D_TMP;
				uop_nxt = S_N_T; end
			S_N_T: begin uop_op = OP_MUL; uop_a = b_q; uop_b = tmp_q; uop_dst = D_T;
				uop_nxt = S_N_AU; end
			S_N_AU: begin uop_op = OP_MUL; uop_a = a_q; uop_b = u_q; uop_dst = D_AU;
				uop_nxt = S_N_BV; end
			S_N_BV: begin uop_op = OP_MUL; uop_a = b_q; uop_b = v_q; uop_dst = D_BV;
				uop_nxt = S_L_CHK; end
			S_L_TPA: begin uop_op = OP_ADD; uop_a = t_q; uop_b = asq_q; uop_dst = D_TPA;
				uop_nxt = S_L_TPB; end
			S_L_TPB: begin uop_op = OP_ADD; uop_a = t_q; uop_b = bsq_q; uop_dst = D_TPB;
				uop_nxt = S_L_XA; end
			S_L_XA: begin uop_op = OP_DIV; uop_a = au_q; uop_b = tpa_q; uop_dst = D_XA;
				uop_nxt = S_L_YB; end
			S_L_YB: begin uop_op = OP_DIV; uop_a = bv_q; uop_b = tpb_q; uop_dst = D_YB;
				uop_nxt = S_L_XA2; end
			S_L_XA2: begin uop_op = OP_MUL; uop_a = xa_q; uop_b = xa_q; uop_dst = D_XA2;
				uop_nxt = S_L_YB2; end
			S_L_YB2: begin uop_op = OP_MUL; uop_a = yb_q; uop_b = yb_q; uop_dst = D_YB2;
				uop_nxt = S_L_FS; end
			S_L_FS: begin uop_op = OP_ADD; uop_a = xa2_q; uop_b = yb2_q; uop_dst = D_F;
				uop_nxt = S_L_F; end
			S_L_F: begin uop_op = OP_SUB; uop_a = f_q; uop_b = ONE; uop_dst = D_F;
				uop_nxt = S_L_FCHK; end
			S_L_DA: begin uop_op = OP_DIV; uop_a = xa2_q; uop_b = tpa_q; uop_dst = D_DER;
				uop_nxt = S_L_DB; end
			S_L_DB: begin uop_op = OP_DIV; uop_a = yb2_q; uop_b = tpb_q; uop_dst = D_TMP;
				uop_nxt = S_L_DS; end
			S_L_DS: begin uop_op = OP_ADD; uop_a = der_q; uop_b = tmp_q; uop_dst = D_DER;
				uop_nxt = S_L_D2; end
			S_L_D2: begin uop_op = OP_ADD; uop_a = der_q; uop_b = der_q; uop_dst = D_DER;
				uop_nxt = S_L_R; end
			S_L_R: begin uop_op = OP_DIV; uop_a = f_q; uop_b = der_q; uop_dst = D_TMP;
				uop_nxt = S_L_RCHK; end
			S_L_T: begin uop_op = OP_ADD; uop_a = t_q; uop_b = tmp_q; uop_dst = D_T;
				uop_nxt = S_L_CHK; end
			S_F_X: begin uop_op = OP_MUL; uop_a = xa_q; uop_b = a_q; uop_dst = D_X;
				uop_nxt = S_F_Y; end
			S_F_Y: begin uop_op = OP_MUL; uop_a = yb_q; uop_b = b_q; uop_dst = D_Y;
				uop_nxt = S_H_DX; end
			S_H_DX: begin uop_op = OP_SUB; uop_a = x_q; uop_b = u_q; uop_dst = D_TMP;
				uop_nxt = S_H_SQX; end
			S_H_SQX: begin uop_op = OP_SQ; uop_a = tmp_q; uop_nxt = S_H_DY; end
			S_H_DY: begin uop_op = OP_SUB; uop_a = y_q; uop_b = v_q; uop_dst = D_TMP;
				uop_nxt = S_H_SQY; end
			S_H_SQY: begin uop_op = OP_SQADD; uop_a = tmp_q; uop_nxt = S_H_RT; end
			S_H_RT: begin uop_op = OP_SQRTW; uop_dst = D_DIST; uop_nxt = S_OUT; end
			S_A_BSQ: begin uop_op = OP_MUL; uop_a = b_q; uop_b = b_q; uop_dst = D_BSQ;
				uop_nxt = S_A_Q; end
			S_A_Q: begin uop_op = OP_DIV; uop_a = bsq_q; uop_b = a_q; uop_dst = D_TMP;
				uop_nxt = S_A_LIM; end
			S_A_LIM: begin uop_op = OP_SUB; uop_a = a_q; uop_b = tmp_q; uop_dst = D_TMP;
				uop_nxt = S_A_CHK; end
			S_A_ASQ: begin uop_op = OP_MUL; uop_a = a_q; uop_b = a_q; uop_dst = D_ASQ;
				uop_nxt = S_A_NUM; end
			S_A_NUM: begin uop_op = OP_MUL; uop_a = asq_q; uop_b = u_q; uop_dst = D_TMP;
				uop_nxt = S_A_DEN; end
			S_A_DEN: begin uop_op = OP_SUB; uop_a = asq_q; uop_b = bsq_q; uop_dst = D_F;
				uop_nxt = S_A_X; end
			S_A_X: begin uop_op = OP_DIV; uop_a = tmp_q; uop_b = f_q; uop_dst = D_X;
				uop_nxt = S_A_XA; end
			S_A_XA: begin uop_op = OP_DIV; uop_a = x_q; uop_b = a_q; uop_dst = D_XA;
				uop_nxt = S_A_XA2; end
			S_A_XA2: begin uop_op = OP_MUL; uop_a = xa_q; uop_b = xa_q; uop_dst = D_XA2;
				uop_nxt = S_A_S; end
			S_A_S: begin uop_op = OP_SUB; uop_a = ONE; uop_b = xa2_q; uop_dst = D_F;
				uop_nxt = S_A_RT; end
			// the root takes the magnitude, so a negative radicand needs no fold here
			S_A_RT: begin uop_op = OP_SQRTQ; uop_a = f_q; uop_dst = D_TMP;
				uop_nxt = S_A_Y; end
			S_A_Y: begin uop_op = OP_MUL; uop_a = b_q; uop_b = tmp_q; uop_dst = D_Y;
				uop_nxt = S_H_DX; end
			S_A_UA: begin uop_op = OP_SUB; uop_a = u_q; uop_b = a_q; uop_dst = D_TMP;
				uop_nxt = S_E_MAG; end
			S_V_VB: begin uop_op = OP_SUB; uop_a = v_q; uop_b = b_q; uop_dst = D_TMP;
				uop_nxt = S_V_MAG; end
			default: begin
			end
		endcase
	end

	always_comb begin
		alu_cmd.start = (uop_op != OP_NONE) && !issued_q;
		alu_cmd.op = uop_op;
		alu_cmd.a = uop_a;
		alu_cmd.b = uop_b;
	end

	ped_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(alu_cmd),
		.done(alu_done),
		.result(alu_res)
	);

	// unfold and pack the result
	always_comb begin
		xo = sw_q ? y_q : x_q;
		yo = sw_q ? x_q : y_q;
		if (rx_q) begin
			xo = sat_neg(xo);
		end
		if (ry_q) begin
			yo = sat_neg(yo);
		end
		x_sh = xo >>> (WORD_BITS - 1);
		y_sh = yo >>> (WORD_BITS - 1);
		if (x_sh == 64'sd0 || x_sh == -64'sd1) begin
			x_pk = xo[WORD_BITS-1:0];
		end else begin
			x_pk = xo[IW-1] ? {1'b1, {AW{1'b0}}} : {1'b0, {AW{1'b1}}};
		end
		if (y_sh == 64'sd0 || y_sh == -64'sd1) begin
			y_pk = yo[WORD_BITS-1:0];
		end else begin
			y_pk = yo[IW-1] ? {1'b1, {AW{1'b0}}} : {1'b0, {AW{1'b1}}};
		end
		dist_pk = ((dist_q >> AW) != '0) ? '1 : dist_q[AW-1:0];
	end

	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (uop_op != OP_NONE) begin
				if (!issued_q) begin
					issued_q <= 1'b1;
				end else if (alu_done) begin
					issued_q <= 1'b0;
					state_q <= uop_nxt;
					case (uop_dst)
						D_TMP: tmp_q <= alu_res;
						D_ASQ: asq_q <= alu_res;
						D_BSQ: bsq_q <= alu_res;
						D_T: t_q <= alu_res;
						D_AU: au_q <= alu_res;
						D_BV: bv_q <= alu_res;
						D_TPA: tpa_q <= alu_res;
						D_TPB: tpb_q <= alu_res;
						D_XA: xa_q <= alu_res;
						D_YB: yb_q <= alu_res;
						D_XA2: xa2_q <= alu_res;
						D_YB2: yb2_q <= alu_res;
						D_F: f_q <= alu_res;
						D_DER: der_q <= alu_res;
						D_X: x_q <= alu_res;
						D_Y: y_q <= alu_res;
						D_DIST: dist_q <= alu_res;
						default: begin
						end
					endcase
					if (state_q == S_L_T) begin
						iter_q <= iter_q + 1'b1;
					end
				end
			end else begin
				case (state_q)
					S_IDLE: begin
						if (start) begin
							u_q <= IW'(point_u);
							v_q <= IW'(point_v);
							state_q <= S_FOLD;
						end
					end
					S_FOLD: begin
						rx_q <= fold_rx;
						ry_q <= fold_ry;
						sw_q <= fold_sw;
						u_q <= fold_sw ? fv : fu;
						v_q <= fold_sw ? fu : fv;
						a_q <= fold_sw ? b_ext : a_ext;
						b_q <= fold_sw ? a_ext : b_ext;
						state_q <= S_BRANCH;
					end
					S_BRANCH: begin
						fail_q <= 1'b0;
						iter_q <= '0;
						if (u_q != '0 && v_q != '0) begin
							state_q <= S_N_ASQ;
						end else if (u_q != '0) begin
							state_q <= S_A_BSQ;
						end else begin
							state_q <= S_V_VB;
						end
					end
					S_L_CHK: state_q <= (iter_q >= cap_eff) ? S_FAIL : S_L_TPA;
					S_L_FCHK: state_q <= (f_q < eps) ? S_F_X : S_L_DA;
					S_L_RCHK: state_q <= (tmp_q < eps) ? S_F_X : S_L_T;
					S_A_CHK: state_q <= (u_q < tmp_q) ? S_A_ASQ : S_A_UA;
					S_E_MAG: begin
						dist_q <= mag(tmp_q);
						x_q <= a_q;
						y_q <= '0;
						state_q <= S_OUT;
					end
					S_V_MAG: begin
						dist_q <= mag(tmp_q);
						x_q <= '0;
						y_q <= b_q;
						state_q <= S_OUT;
					end
					S_FAIL: begin
						fail_q <= 1'b1;
						state_q <= S_OUT;
					end
					S_OUT: begin
						done <= 1'b1;
						if (fail_q) begin
							distance <= '0;
							closest_x <= '0;
							closest_y <= '0;
							iterations_used <= FAIL_ITERS;
							failed <= 1'b1;
						end else begin
							distance <= dist_pk;
							closest_x <= x_pk;
							closest_y <= y_pk;
							iterations_used <= iter_q[ITER_BITS-1:0];
							failed <= 1'b0;
						end
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && failed |-> distance == '0 && iterations_used == FAIL_ITERS)
		else $error("failed result carries data");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("start transfer not taken");

	a_alu_owned: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> issued_q)
		else $error("unit finished with no operation outstanding");

	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && !failed |-> iterations_used == '0 || CAP_BITS'(iterations_used) < cap_eff)
		else $error("iteration count beyond cap");
`endif

endmodule

`default_nettype wire
